// ----- hw/rtl/htc_pkg.sv -----
// ----------------------------------------------------------------------------
// htc_pkg: shared types and constants
// Field widths, conversion constants, register indexes and the command and
// status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package htc_pkg;

    // Field widths
    localparam int TEMP_RAW_W = 14;
    localparam int HUMI_RAW_W = 12;
    localparam int TEMP_W     = 15;
    localparam int HUMI_W     = 16;
    localparam int TTHR_W     = 8;
    localparam int HTHR_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Internal widths, sized to the value ranges of the conversion
    localparam int P1_W   = 27;   // (T100 - 2500) * (125 + S)
    localparam int P2_W   = 24;   // S * S
    localparam int N_W    = 30;   // humidity numerator N
    localparam int BIAS_W = 29;   // N plus bias, always non-negative
    localparam int X_W    = 26;   // biased N divided by 8
    localparam int RCP_W  = 27;   // reciprocal of 3125
    localparam int PROD_W = X_W + RCP_W;
    localparam int Q_W    = 15;   // biased quotient

    // Conversion constants
    localparam int T_OFFSET   = 3966;
    localparam int T_MID      = 2500;
    localparam int S_OFFSET   = 125;
    localparam int LIN_COEF   = 101250;
    localparam int SQ_COEF    = 7;
    localparam int N_OFFSET   = 10000000;
    localparam int T_SCALE    = 100;
    localparam int H_SCALE    = 2500000;

    // floor(N / 25000) = floor(((N + Q_BIAS * 25000) >> 3) / 3125) - Q_BIAS
    localparam int Q_BIAS     = 512;
    localparam int N_BIAS     = Q_BIAS * 25000;
    localparam int DIV_PRE    = 3;
    localparam int DIV_SHIFT  = 38;
    localparam int RCP_3125   = 87960931;   // ceil(2^38 / 3125)

    // Register reset values
    localparam int LAMP_ON_RST  = 38;
    localparam int LAMP_OFF_RST = 40;
    localparam int FAN_ON_RST   = 60;
    localparam int FAN_OFF_RST  = 55;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAMP_ON  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAMP_OFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_ON   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_OFF  = 2'd3;

    // Datapath step commands, one per cycle at most
    typedef struct packed {
        logic load;
        logic mul_ab;
        logic mul_ss;
        logic sum_lin;
        logic sum_sq;
        logic divide;
        logic out_load;
    } t_dp_cmd;

    // Datapath status back to the controller
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ----- hw/rtl/htc_in_if.sv -----
// ----------------------------------------------------------------------------
// htc_in_if: raw sensor sample channel
// Valid/ready channel that carries one raw temperature and humidity count.
// ----------------------------------------------------------------------------
interface htc_in_if import htc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [TEMP_RAW_W-1:0] temp_raw;
    logic [HUMI_RAW_W-1:0] humi_raw;

    modport source (output valid, output temp_raw, output humi_raw, input ready);
    modport sink   (input valid, input temp_raw, input humi_raw, output ready);
endinterface

// ----- hw/rtl/htc_out_if.sv -----
// ----------------------------------------------------------------------------
// htc_out_if: converted result channel
// Valid/ready channel that carries the converted readings and drive states.
// ----------------------------------------------------------------------------
interface htc_out_if import htc_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature_c100;
    logic signed [HUMI_W-1:0] humidity_c100;
    logic                     lamp_state;
    logic                     fan_state;

    modport source (output valid, output temperature_c100, output humidity_c100,
                    output lamp_state, output fan_state, input ready);
    modport sink   (input valid, input temperature_c100, input humidity_c100,
                    input lamp_state, input fan_state, output ready);
endinterface

// ----- hw/rtl/htc_ctrl.sv -----
// ----------------------------------------------------------------------------
// htc_ctrl: conversion sequencer
// Steps one sample through load, two multiplies, two sums, the divide and
// the output load, issuing one datapath command per state.
// ----------------------------------------------------------------------------
module htc_ctrl import htc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAB  = 3'd1;
    localparam logic [2:0] ST_MSS  = 3'd2;
    localparam logic [2:0] ST_SLIN = 3'd3;
    localparam logic [2:0] ST_SSQ  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MAB;
                end
            end
            ST_MAB: begin
                o_cmd.mul_ab = 1'b1;
                n_state      = ST_MSS;
            end
            ST_MSS: begin
                o_cmd.mul_ss = 1'b1;
                n_state      = ST_SLIN;
            end
            ST_SLIN: begin
                o_cmd.sum_lin = 1'b1;
                n_state       = ST_SSQ;
            end
            ST_SSQ: begin
                o_cmd.sum_sq = 1'b1;
                n_state      = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.divide = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                // Wait here until the output register can take the result.
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hw/rtl/htc_dp.sv -----
// ----------------------------------------------------------------------------
// htc_dp: conversion datapath
// Threshold registers, the exact fixed-point humidity numerator, the floor
// divide by 25000 through a reciprocal multiply, the hysteresis states and
// the output register.
// ----------------------------------------------------------------------------
module htc_dp import htc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    output t_dp_sts                  o_sts,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic [TEMP_RAW_W-1:0]    i_temp_raw,
    input  logic [HUMI_RAW_W-1:0]    i_humi_raw,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [TEMP_W-1:0] o_temperature_c100,
    output logic signed [HUMI_W-1:0] o_humidity_c100,
    output logic                     o_lamp_state,
    output logic                     o_fan_state
);

    // Threshold registers
    logic signed [TTHR_W-1:0] r_lamp_on_thr;
    logic signed [TTHR_W-1:0] r_lamp_off_thr;
    logic [HTHR_W-1:0]        r_fan_on_thr;
    logic [HTHR_W-1:0]        r_fan_off_thr;

    // Working registers
    logic signed [TEMP_W-1:0] r_t100;
    logic [HUMI_RAW_W-1:0]    r_s;
    logic signed [P1_W-1:0]   r_p1;
    logic [P2_W-1:0]          r_p2;
    logic signed [N_W-1:0]    r_acc;
    logic signed [N_W-1:0]    r_n;
    logic [Q_W-1:0]           r_q;
    logic                     r_lamp;
    logic                     r_fan;
    logic                     r_out_valid;

    logic                     n_lamp;
    logic                     n_fan;

    logic signed [TEMP_W-1:0] w_a;
    logic signed [13:0]       w_b;
    logic signed [P1_W+1:0]   w_p1_full;
    logic [P2_W-1:0]          w_p2;
    logic signed [31:0]       w_lin;
    logic [26:0]              w_sq7;
    logic signed [N_W:0]      w_n_full;
    logic [BIAS_W-1:0]        w_biased;
    logic [X_W-1:0]           w_x;
    logic [PROD_W-1:0]        w_prod;
    logic signed [TEMP_W-1:0] w_lamp_on_lim;
    logic signed [TEMP_W-1:0] w_lamp_off_lim;
    logic [N_W-1:0]           w_fan_on_lim;
    logic [N_W-1:0]           w_fan_off_lim;

    // Configuration writes; the decode covers all four register indexes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp_on_thr  <= TTHR_W'(LAMP_ON_RST);
            r_lamp_off_thr <= TTHR_W'(LAMP_OFF_RST);
            r_fan_on_thr   <= HTHR_W'(FAN_ON_RST);
            r_fan_off_thr  <= HTHR_W'(FAN_OFF_RST);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_LAMP_ON:  r_lamp_on_thr  <= i_cfg_wdata[TTHR_W-1:0];
                REG_LAMP_OFF: r_lamp_off_thr <= i_cfg_wdata[TTHR_W-1:0];
                REG_FAN_ON:   r_fan_on_thr   <= i_cfg_wdata[HTHR_W-1:0];
                REG_FAN_OFF:  r_fan_off_thr  <= i_cfg_wdata[HTHR_W-1:0];
                default: ;
            endcase
        end
    end

    // First product: (T100 - 2500) * (125 + S); both fit their narrow widths.
    assign w_a       = r_t100 - TEMP_W'(T_MID);
    assign w_b       = $signed({1'b0, 13'(r_s) + 13'(S_OFFSET)});
    assign w_p1_full = w_a * w_b;

    // Second product: S squared.
    assign w_p2 = P2_W'(r_s) * P2_W'(r_s);

    // Linear terms: 2 * p1 + 101250 * S - 10000000.
    assign w_lin = (32'(r_p1) <<< 1) + $signed(32'(r_s) * 32'(LIN_COEF))
                   - 32'sd10000000;

    // Square term: N = acc - 7 * S^2.
    assign w_sq7    = 27'(r_p2) * 27'(SQ_COEF);
    assign w_n_full = 31'(r_acc) - $signed({4'b0000, w_sq7});

    // Floor divide: bias N non-negative, drop the factor of 8, then
    // multiply by the reciprocal of 3125, exact for every 26-bit value.
    assign w_biased = BIAS_W'(r_n + N_W'(N_BIAS));
    assign w_x      = w_biased[BIAS_W-1:DIV_PRE];
    assign w_prod   = PROD_W'(w_x) * PROD_W'(RCP_3125);

    // Hysteresis limits in the units of T100 and N.
    assign w_lamp_on_lim  = TEMP_W'(r_lamp_on_thr) * TEMP_W'(T_SCALE);
    assign w_lamp_off_lim = TEMP_W'(r_lamp_off_thr) * TEMP_W'(T_SCALE);
    assign w_fan_on_lim   = N_W'(r_fan_on_thr) * N_W'(H_SCALE);
    assign w_fan_off_lim  = N_W'(r_fan_off_thr) * N_W'(H_SCALE);

    // Next drive states
    always_comb begin
        n_lamp = r_lamp;
        if (!r_lamp && (r_t100 < w_lamp_on_lim)) begin
            n_lamp = 1'b1;
        end else if (r_lamp && (r_t100 > w_lamp_off_lim)) begin
            n_lamp = 1'b0;
        end
        n_fan = r_fan;
        if (!r_fan && (r_n > $signed(w_fan_on_lim))) begin
            n_fan = 1'b1;
        end else if (r_fan && (r_n < $signed(w_fan_off_lim))) begin
            n_fan = 1'b0;
        end
    end

    // Conversion registers, one step per command
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t100 <= $signed({1'b0, i_temp_raw}) - TEMP_W'(T_OFFSET);
            r_s    <= i_humi_raw;
        end
        if (i_cmd.mul_ab) begin
            r_p1 <= P1_W'(w_p1_full);
        end
        if (i_cmd.mul_ss) begin
            r_p2 <= w_p2;
        end
        if (i_cmd.sum_lin) begin
            r_acc <= N_W'(w_lin);
        end
        if (i_cmd.sum_sq) begin
            r_n <= N_W'(w_n_full);
        end
        if (i_cmd.divide) begin
            r_q <= w_prod[DIV_SHIFT+Q_W-1:DIV_SHIFT];
        end
    end

    // Drive states
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp <= 1'b0;
            r_fan  <= 1'b0;
        end else if (i_cmd.divide) begin
            r_lamp <= n_lamp;
            r_fan  <= n_fan;
        end
    end

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_temperature_c100 <= r_t100;
            o_humidity_c100    <= $signed(HUMI_W'(r_q) - HUMI_W'(Q_BIAS));
            o_lamp_state       <= r_lamp;
            o_fan_state        <= r_fan;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

// ----- hw/rtl/humidity_temp_convert_and_thermostat_unit.sv -----
// ----------------------------------------------------------------------------
// humidity_temp_convert_and_thermostat_unit: sensor conversion and control
// Converts raw temperature and humidity counts to hundredths of a degree and
// of a percent, and runs a hysteresis lamp thermostat and fan humidistat.
// ----------------------------------------------------------------------------
// Each accepted sample walks the sequencer states, one narrow multiply, add
// or reciprocal-multiply per state, until its result sits in the output
// register; the next sample is taken once the sequencer is back in idle.
// The sequencer waits before the output load while the output side does not
// keep up. A new sample is accepted while the previous result still waits to
// be taken. The user is to write thresholds through the configuration port
// only while the block is idle; the block itself does not enforce this.
// Thresholds so written take effect from the next sample.
module humidity_temp_convert_and_thermostat_unit import htc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    htc_in_if.sink                i_sensor,
    htc_out_if.source             o_result,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    // Sequencer
    htc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sensor.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath
    htc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_temp_raw         (i_sensor.temp_raw),
        .i_humi_raw         (i_sensor.humi_raw),
        .i_out_ready        (o_result.ready),
        .o_out_valid        (o_result.valid),
        .o_temperature_c100 (o_result.temperature_c100),
        .o_humidity_c100    (o_result.humidity_c100),
        .o_lamp_state       (o_result.lamp_state),
        .o_fan_state        (o_result.fan_state)
    );

    assign i_sensor.ready = w_in_ready;

endmodule

// ----- hw/rtl/htc_checker.sv -----
// ----------------------------------------------------------------------------
// htc_checker: port-level checks
// Watches the channels of the top level over time; bound to the top level.
// ----------------------------------------------------------------------------
module htc_checker import htc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    htc_in_if.sink    i_sensor,
    htc_out_if.source o_result
);

    // A waiting result holds until its transfer completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.ready |=>
            o_result.valid && $stable(o_result.temperature_c100)
            && $stable(o_result.humidity_c100) && $stable(o_result.lamp_state)
            && $stable(o_result.fan_state))
        else $error("result changed while stalled");

    // One sample at a time: no input transfer right after another.
    a_in_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sensor.valid && i_sensor.ready |=> !i_sensor.ready)
        else $error("input taken while a sample is in work");

    // A new result is loaded only while the input side is closed.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(!i_sensor.ready))
        else $error("result appeared without a sample in work");

    // Reset leaves no result pending.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result pending after reset");

endmodule

bind humidity_temp_convert_and_thermostat_unit htc_checker u_htc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_sensor (i_sensor),
    .o_result (o_result)
);
